// File: rtl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/msl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package msl_pkg;

    localparam int MAX_ITEMS     = 256;
    localparam int VALUE_WIDTH   = 16;
    localparam int IN_WIDTH      = 16;
    localparam int OUT_LEN_WIDTH = 9;
    localparam int ADDR_WIDTH    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int LEN_WIDTH     = $clog2(MAX_ITEMS + 1);
    localparam int MAX_OUT_LEN   = (MAX_ITEMS < (1 << OUT_LEN_WIDTH)) ?
                                   MAX_ITEMS : ((1 << OUT_LEN_WIDTH) - 1);

    typedef logic [VALUE_WIDTH-1:0]   val_t;
    typedef logic [IN_WIDTH-1:0]      in_val_t;
    typedef logic [LEN_WIDTH-1:0]     len_t;
    typedef logic [ADDR_WIDTH-1:0]    addr_t;
    typedef logic [OUT_LEN_WIDTH-1:0] olen_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_SEARCH,
        ST_FINISH
    } state_t;

    function automatic val_t trim_value(in_val_t raw);
        logic [VALUE_WIDTH+IN_WIDTH-1:0] ext;
        ext = {{VALUE_WIDTH{1'b0}}, raw};
        return ext[VALUE_WIDTH-1:0];
    endfunction

    function automatic olen_t to_out_len(len_t len);
        logic [LEN_WIDTH+OUT_LEN_WIDTH-1:0] ext;
        ext = {{OUT_LEN_WIDTH{1'b0}}, len};
        return ext[OUT_LEN_WIDTH-1:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/msl_tail_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module msl_tail_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 16
) (
    input  wire logic                                     clk,
    input  wire logic                                     we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                         wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/monotone_subsequence_length.sv
// channel | signals                          | direction
// --------+----------------------------------+----------
// in      | in_valid, in_ready, value, last  | into block
// out     | out_valid, out_ready, inc_length,| out of block
//         | dec_length, overflow             |
//
// each word runs two binary searches in turn through one shared comparator,
// one probe per cycle on the registered tail ram read port
// each word runs setup and search on the rising tails, then setup and search on the falling tails, then finish
// a word beyond the item limit skips both searches: idle goes straight to finish and only overflow is set
// reset clears lengths, count, overflow flag and output valid; tail rams and the result word are not cleared
// a last word waits in the finish state while the output register holds a result not yet taken
`timescale 1ns / 1ps
`default_nettype none

module monotone_subsequence_length (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire msl_pkg::in_val_t  value,
    input  wire logic              last,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output msl_pkg::olen_t         inc_length,
    output msl_pkg::olen_t         dec_length,
    output logic                   overflow
);

    import msl_pkg::*;

    state_t state_reg, state_next;
    val_t   value_reg, value_next;
    logic   last_reg, last_next;
    logic   fall_sel_reg, fall_sel_next;
    len_t   lo_reg, lo_next;
    len_t   hi_reg, hi_next;
    len_t   mid_reg, mid_next;
    len_t   rise_len_reg, rise_len_next;
    len_t   fall_len_reg, fall_len_next;
    len_t   count_reg, count_next;
    logic   ovf_reg, ovf_next;
    olen_t  inc_length_reg, inc_length_next;
    olen_t  dec_length_reg, dec_length_next;
    logic   overflow_reg, overflow_next;
    logic   out_valid_reg, out_valid_next;

    logic   in_accept;
    logic   out_free;
    logic   search_done;
    logic   keep;
    logic   slot_ok;
    len_t   cur_len;
    val_t   tail;
    val_t   cmp_a;
    val_t   cmp_b;
    val_t   rise_rdata;
    val_t   fall_rdata;
    logic   rise_we;
    logic   fall_we;
    addr_t  raddr;

    function automatic len_t mid_of(len_t lo, len_t hi);
        logic [LEN_WIDTH:0] sum;
        sum = {1'b0, lo} + {1'b0, hi};
        return sum[LEN_WIDTH:1];
    endfunction

    assign in_ready    = (state_reg == ST_IDLE);
    assign in_accept   = in_valid && in_ready;
    assign out_free    = !out_valid_reg || out_ready;
    assign cur_len     = fall_sel_reg ? fall_len_reg : rise_len_reg;
    assign tail        = fall_sel_reg ? fall_rdata : rise_rdata;
    assign cmp_a       = fall_sel_reg ? value_reg : tail;
    assign cmp_b       = fall_sel_reg ? tail : value_reg;
    assign keep        = (cmp_a < cmp_b);
    assign search_done = !(lo_reg < hi_reg);
    assign slot_ok     = (lo_reg < len_t'(MAX_ITEMS));
    assign raddr       = mid_next[ADDR_WIDTH-1:0];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = (count_reg < len_t'(MAX_ITEMS)) ? ST_SETUP : ST_FINISH;
                end
            end
            ST_SETUP:
            begin
                state_next = ST_SEARCH;
            end
            ST_SEARCH:
            begin
                if (search_done)
                begin
                    state_next = fall_sel_reg ? ST_FINISH : ST_SETUP;
                end
            end
            ST_FINISH:
            begin
                if (!last_reg || out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        value_next      = value_reg;
        last_next       = last_reg;
        fall_sel_next   = fall_sel_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        rise_len_next   = rise_len_reg;
        fall_len_next   = fall_len_reg;
        count_next      = count_reg;
        ovf_next        = ovf_reg;
        inc_length_next = inc_length_reg;
        dec_length_next = dec_length_reg;
        overflow_next   = overflow_reg;
        out_valid_next  = out_valid_reg;
        rise_we         = 1'b0;
        fall_we         = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    value_next    = trim_value(value);
                    last_next     = last;
                    fall_sel_next = 1'b0;
                    if (count_reg < len_t'(MAX_ITEMS))
                    begin
                        count_next = count_reg + len_t'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
            end
            ST_SETUP:
            begin
                lo_next  = '0;
                hi_next  = cur_len;
                mid_next = mid_of('0, cur_len);
            end
            ST_SEARCH:
            begin
                if (!search_done)
                begin
                    if (keep)
                    begin
                        lo_next = mid_reg + len_t'(1);
                    end
                    else
                    begin
                        hi_next = mid_reg;
                    end
                    mid_next = mid_of(lo_next, hi_next);
                end
                else
                begin
                    // slot found: replace or extend
                    rise_we       = slot_ok && !fall_sel_reg;
                    fall_we       = slot_ok && fall_sel_reg;
                    fall_sel_next = 1'b1;
                    if (slot_ok && (lo_reg == cur_len))
                    begin
                        if (fall_sel_reg)
                        begin
                            fall_len_next = fall_len_reg + len_t'(1);
                        end
                        else
                        begin
                            rise_len_next = rise_len_reg + len_t'(1);
                        end
                    end
                end
            end
            ST_FINISH:
            begin
                if (last_reg && out_free)
                begin
                    inc_length_next = to_out_len(rise_len_reg);
                    dec_length_next = to_out_len(fall_len_reg);
                    overflow_next   = ovf_reg;
                    out_valid_next  = 1'b1;
                    rise_len_next   = '0;
                    fall_len_next   = '0;
                    count_next      = '0;
                    ovf_next        = 1'b0;
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fall_sel_reg  <= 1'b0;
            rise_len_reg  <= '0;
            fall_len_reg  <= '0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fall_sel_reg  <= fall_sel_next;
            rise_len_reg  <= rise_len_next;
            fall_len_reg  <= fall_len_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg      <= value_next;
        last_reg       <= last_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        inc_length_reg <= inc_length_next;
        dec_length_reg <= dec_length_next;
        overflow_reg   <= overflow_next;
    end

    msl_tail_ram #(
        .DEPTH (MAX_ITEMS),
        .WIDTH (VALUE_WIDTH)
    ) u_rise_ram (
        .clk   (clk),
        .we    (rise_we),
        .waddr (lo_reg[ADDR_WIDTH-1:0]),
        .wdata (value_reg),
        .raddr (raddr),
        .rdata (rise_rdata)
    );

    msl_tail_ram #(
        .DEPTH (MAX_ITEMS),
        .WIDTH (VALUE_WIDTH)
    ) u_fall_ram (
        .clk   (clk),
        .we    (fall_we),
        .waddr (lo_reg[ADDR_WIDTH-1:0]),
        .wdata (value_reg),
        .raddr (raddr),
        .rdata (fall_rdata)
    );

    assign out_valid  = out_valid_reg;
    assign inc_length = inc_length_reg;
    assign dec_length = dec_length_reg;
    assign overflow   = overflow_reg;

endmodule

`default_nettype wire

// File: rtl/msl_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module msl_checker (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             in_valid,
    input wire logic             in_ready,
    input wire logic             out_valid,
    input wire logic             out_ready,
    input wire msl_pkg::olen_t   inc_length,
    input wire msl_pkg::olen_t   dec_length,
    input wire logic             overflow
);

    import msl_pkg::*;

    // a taken word keeps the block busy in the cycle after it was taken
    `ASSERT_NEXT(a_busy_after_word, clk, rst_n, in_valid && in_ready, !in_ready,
        "input ready right after a word was taken")

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(inc_length) && $stable(dec_length) && $stable(overflow),
        "stalled result word changed")

    `ASSERT_IMPL(a_len_bound, clk, rst_n, out_valid,
        (inc_length <= olen_t'(MAX_OUT_LEN)) && (dec_length <= olen_t'(MAX_OUT_LEN)),
        "result length above item limit")

    // a result appears only out of a busy cycle
    `ASSERT_IMPL(a_result_from_busy, clk, rst_n, $rose(out_valid), $past(!in_ready),
        "result raised while block was idle")

endmodule

bind monotone_subsequence_length msl_checker u_msl_checker (.*);

`default_nettype wire
